// ===== rtl/aifa_pkg.sv =====
package aifa_pkg;

    // Register map: register i sits at byte address 4*i.
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned TIME_W   = 32;

    typedef enum logic [1:0] {
        REG_WINDOW   = 2'd0,
        REG_SUSTAIN  = 2'd1,
        REG_SUPPRESS = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd500;
    localparam logic [CFG_W-1:0] SUSTAIN_RST  = 16'd2000;
    localparam logic [CFG_W-1:0] SUPPRESS_RST = 16'd10000;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_SUSPECT  = 2'd2,
        MODE_COOLDOWN = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_AUDIO   = 2'd0,
        EV_IMPACT  = 2'd1,
        EV_FIRED   = 2'd2,
        EV_CLEARED = 2'd3
    } kind_t;

    localparam int unsigned FLAG_LOUD   = 0;
    localparam int unsigned FLAG_HF     = 1;
    localparam int unsigned FLAG_IMPACT = 2;

    typedef struct packed {
        logic [CFG_W-1:0] correlation_window_ms;
        logic [CFG_W-1:0] sustain_ms;
        logic [CFG_W-1:0] suppression_ms;
    } cfg_t;

    typedef struct packed {
        logic               armed;
        logic [TIME_W-1:0]  now_ms;
        logic               loud_trig;
        logic               trig_hf;
        logic               impact;
        logic signed [31:0] rms_in;
        logic signed [31:0] peak_in;
        logic [15:0]        zcr_in;
        logic signed [31:0] hfe_in;
        logic signed [31:0] mag_mg_in;
        logic signed [31:0] peak_delta_mg_in;
        logic signed [31:0] impulse_mg_in;
    } in_beat_t;

    typedef struct packed {
        kind_t              event_kind;
        logic [TIME_W-1:0]  stamp_ms;
        mode_t              mode_code;
        logic [2:0]         trigger_flags;
        logic signed [15:0] rms_out;
        logic signed [15:0] peak_out;
        logic [14:0]        zcr_q15_out;
        logic [15:0]        hfe_out;
        logic signed [15:0] mag_mg_out;
        logic signed [15:0] peak_delta_mg_out;
        logic [15:0]        impulse_mg_out;
    } out_beat_t;

endpackage

// ===== rtl/aifa_cfg.sv =====
module aifa_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aifa_pkg::ADDR_W-1:0]   paddr,
    input  logic [aifa_pkg::DATA_W-1:0]   pwdata,
    output logic [aifa_pkg::DATA_W-1:0]   prdata,
    output aifa_pkg::cfg_t                cfg
);

    aifa_pkg::cfg_t   cfg_reg;
    aifa_pkg::reg_idx_t idx;
    logic             wr_en;

    // Word index; the low address bits select bytes within a word and are ignored.
    assign idx   = aifa_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.correlation_window_ms <= aifa_pkg::WINDOW_RST;
            cfg_reg.sustain_ms            <= aifa_pkg::SUSTAIN_RST;
            cfg_reg.suppression_ms        <= aifa_pkg::SUPPRESS_RST;
        end else if (wr_en) begin
            case (idx)
                aifa_pkg::REG_WINDOW: begin
                    cfg_reg.correlation_window_ms <= pwdata[aifa_pkg::CFG_W-1:0];
                end
                aifa_pkg::REG_SUSTAIN: begin
                    cfg_reg.sustain_ms <= pwdata[aifa_pkg::CFG_W-1:0];
                end
                aifa_pkg::REG_SUPPRESS: begin
                    cfg_reg.suppression_ms <= pwdata[aifa_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            aifa_pkg::REG_WINDOW:   prdata = {16'd0, cfg_reg.correlation_window_ms};
            aifa_pkg::REG_SUSTAIN:  prdata = {16'd0, cfg_reg.sustain_ms};
            aifa_pkg::REG_SUPPRESS: prdata = {16'd0, cfg_reg.suppression_ms};
            default:                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/aifa_snap.sv =====
module aifa_snap (
    input  aifa_pkg::in_beat_t  beat,
    input  aifa_pkg::kind_t     kind,
    input  aifa_pkg::mode_t     snap_mode,
    output aifa_pkg::out_beat_t snap
);

    function automatic logic [15:0] sat_i16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v < 32'sd0) begin
            r = 16'h0000;
        end else if (v > 32'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Q15 mapping: zero stays zero, 1.0 and above clamps to full scale.
    function automatic logic [14:0] zcr_q15(input logic [15:0] v);
        logic [14:0] r;
        if (v == 16'd0) begin
            r = 15'd0;
        end else if (v[15]) begin
            r = 15'h7FFF;
        end else begin
            r = v[14:0] - 15'd1;
        end
        return r;
    endfunction

    always_comb begin
        snap.event_kind        = kind;
        snap.stamp_ms          = beat.now_ms;
        snap.mode_code         = snap_mode;
        snap.trigger_flags     = '0;
        snap.trigger_flags[aifa_pkg::FLAG_LOUD]   = beat.loud_trig;
        snap.trigger_flags[aifa_pkg::FLAG_HF]     = beat.trig_hf;
        snap.trigger_flags[aifa_pkg::FLAG_IMPACT] = beat.impact;
        snap.rms_out           = sat_i16(beat.rms_in);
        snap.peak_out          = sat_i16(beat.peak_in);
        snap.zcr_q15_out       = zcr_q15(beat.zcr_in);
        snap.hfe_out           = sat_u16(beat.hfe_in);
        snap.mag_mg_out        = sat_i16(beat.mag_mg_in);
        snap.peak_delta_mg_out = sat_i16(beat.peak_delta_mg_in);
        snap.impulse_mg_out    = sat_u16(beat.impulse_mg_in);
    end

endmodule

// ===== rtl/audio_impact_fusion_alert_fsm.sv =====
// Audio and impact alert fusion. Each input beat is one tick: an armed flag, a
// millisecond time stamp, the loud, high-frequency and impact triggers, and the raw
// feature values. The block runs a four-mode machine (disarmed, idle, suspect,
// cooldown) and emits at most one event beat per tick: audio suspect, impact
// suspect, alert fired or alert cleared, each with a saturated 16-bit feature
// snapshot. A tick that causes no event produces no output beat. Throughput is one
// tick per clock cycle while m_ready does not stall the result register. An accepted
// tick sits in the input register, and its event appears on m_valid when the result
// register takes it. The mode and time update for a tick is computed while it sits
// in the input register and registered as it leaves, so consecutive ticks see each
// other's effects without bubbles.
// The three timing registers are written over the APB port at byte addresses 0, 4
// and 8 and should only be changed while no ticks are in flight.
module audio_impact_fusion_alert_fsm (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  aifa_pkg::in_beat_t            s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output aifa_pkg::out_beat_t           m_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aifa_pkg::ADDR_W-1:0]   paddr,
    input  logic [aifa_pkg::DATA_W-1:0]   pwdata,
    output logic [aifa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned TW = aifa_pkg::TIME_W;

    aifa_pkg::cfg_t      cfg;

    // Input register: holds the tick being evaluated this cycle.
    aifa_pkg::in_beat_t  in_reg;
    logic                in_vld_reg;
    logic                in_vld_next;

    // Result register.
    aifa_pkg::out_beat_t m_data_reg;
    logic                m_valid_reg;
    logic                m_valid_next;

    // Machine state.
    aifa_pkg::mode_t     mode_reg, mode_next;
    logic [TW-1:0]       start_reg, start_next;
    logic [TW-1:0]       audio_t_reg, audio_t_next;
    logic [TW-1:0]       impact_t_reg, impact_t_next;
    logic [TW-1:0]       cool_end_reg, cool_end_next;

    logic                s_fire;
    logic                advance;
    logic                audio_hit;
    logic                impact_sus;
    aifa_pkg::mode_t     cur_mode;
    logic [TW-1:0]       now;
    logic [TW-1:0]       win;
    logic [TW-1:0]       la, li;
    logic [TW-1:0]       elapsed;
    logic                recent_a, recent_i;
    logic [TW-1:0]       alert_end;

    logic                ev_valid;
    aifa_pkg::kind_t     ev_kind;
    aifa_pkg::mode_t     ev_mode;
    aifa_pkg::out_beat_t snap;

    aifa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // A tick leaves the input register whenever the result register can take a
    // beat, whether or not the tick produces an event.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    // Decoding of the held tick.
    assign now        = in_reg.now_ms;
    assign win        = {16'd0, cfg.correlation_window_ms};
    // Audio suspicion needs both audio triggers together.
    assign audio_hit  = in_reg.loud_trig && in_reg.trig_hf;
    assign impact_sus = in_reg.impact;
    // Arming out of disarmed behaves as idle for the same tick.
    assign cur_mode   = (mode_reg == aifa_pkg::MODE_DISARMED) ? aifa_pkg::MODE_IDLE
                                                              : mode_reg;

    // Trigger times as updated by this tick, then their window checks. A trigger
    // only counts if it is no older than the start of the current suspicion.
    assign la        = audio_hit  ? now : audio_t_reg;
    assign li        = impact_sus ? now : impact_t_reg;
    assign elapsed   = now - start_reg;
    assign recent_a  = (la >= start_reg) && ((now - la) <= win);
    assign recent_i  = (li >= start_reg) && ((now - li) <= win);
    assign alert_end = now + {16'd0, cfg.suppression_ms};

    always_comb begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        audio_t_next  = audio_t_reg;
        impact_t_next = impact_t_reg;
        cool_end_next = cool_end_reg;
        ev_valid      = 1'b0;
        ev_kind       = aifa_pkg::EV_FIRED;
        ev_mode       = aifa_pkg::MODE_IDLE;

        if (advance) begin
            if (!in_reg.armed) begin
                mode_next = aifa_pkg::MODE_DISARMED;
            end else begin
                case (cur_mode)
                    aifa_pkg::MODE_IDLE: begin
                        mode_next = aifa_pkg::MODE_IDLE;
                        if (audio_hit && impact_sus) begin
                            // Compound trigger straight from idle: the trigger
                            // times are left as they were.
                            ev_valid      = 1'b1;
                            ev_kind       = aifa_pkg::EV_FIRED;
                            ev_mode       = aifa_pkg::MODE_IDLE;
                            mode_next     = aifa_pkg::MODE_COOLDOWN;
                            cool_end_next = alert_end;
                        end else if (audio_hit || impact_sus) begin
                            ev_valid      = 1'b1;
                            ev_kind       = audio_hit ? aifa_pkg::EV_AUDIO
                                                      : aifa_pkg::EV_IMPACT;
                            ev_mode       = aifa_pkg::MODE_SUSPECT;
                            mode_next     = aifa_pkg::MODE_SUSPECT;
                            start_next    = now;
                            audio_t_next  = la;
                            impact_t_next = li;
                        end
                    end
                    aifa_pkg::MODE_SUSPECT: begin
                        audio_t_next  = la;
                        impact_t_next = li;
                        if ((recent_a && recent_i) ||
                            ((elapsed >= {16'd0, cfg.sustain_ms}) &&
                             (audio_hit || impact_sus))) begin
                            ev_valid      = 1'b1;
                            ev_kind       = aifa_pkg::EV_FIRED;
                            ev_mode       = aifa_pkg::MODE_SUSPECT;
                            mode_next     = aifa_pkg::MODE_COOLDOWN;
                            cool_end_next = alert_end;
                        end else if (!audio_hit && !impact_sus && (elapsed > win)) begin
                            // No trigger on this tick and the suspicion started more than a window ago.
                            mode_next = aifa_pkg::MODE_IDLE;
                        end
                    end
                    aifa_pkg::MODE_COOLDOWN: begin
                        // Plain unsigned compare against the stored end time.
                        if (now >= cool_end_reg) begin
                            ev_valid  = 1'b1;
                            ev_kind   = aifa_pkg::EV_CLEARED;
                            ev_mode   = aifa_pkg::MODE_IDLE;
                            mode_next = aifa_pkg::MODE_IDLE;
                        end
                    end
                    default: begin
                        mode_next = aifa_pkg::MODE_IDLE;
                    end
                endcase
            end
        end
    end

    aifa_snap u_snap (
        .beat      (in_reg),
        .kind      (ev_kind),
        .snap_mode (ev_mode),
        .snap      (snap)
    );

    always_comb begin
        if (advance) begin
            m_valid_next = ev_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= aifa_pkg::MODE_DISARMED;
            start_reg    <= '0;
            audio_t_reg  <= '0;
            impact_t_reg <= '0;
            cool_end_reg <= '0;
        end else begin
            in_vld_reg   <= in_vld_next;
            m_valid_reg  <= m_valid_next;
            mode_reg     <= mode_next;
            start_reg    <= start_next;
            audio_t_reg  <= audio_t_next;
            impact_t_reg <= impact_t_next;
            cool_end_reg <= cool_end_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
        if (advance && ev_valid) begin
            m_data_reg <= snap;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/aifa_checker.sv =====
module aifa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input aifa_pkg::in_beat_t            s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input aifa_pkg::out_beat_t           m_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [aifa_pkg::ADDR_W-1:0]   paddr,
    input logic [aifa_pkg::DATA_W-1:0]   pwdata,
    input logic [aifa_pkg::DATA_W-1:0]   prdata,
    input logic                          pready
);

    // No event beat may be offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("event beat offered straight after reset");

    // A stalled event beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled event beat changed");

    // Audio suspect events only ever report the suspect mode and carry both audio triggers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == aifa_pkg::EV_AUDIO) |->
            (m_data.mode_code == aifa_pkg::MODE_SUSPECT) &&
            m_data.trigger_flags[aifa_pkg::FLAG_LOUD] &&
            m_data.trigger_flags[aifa_pkg::FLAG_HF])
        else $error("audio suspect event with wrong mode or flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == aifa_pkg::EV_CLEARED) |->
            (m_data.mode_code == aifa_pkg::MODE_IDLE))
        else $error("clear event not reported in idle mode");

    // An alert can only fire from idle or suspect.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == aifa_pkg::EV_FIRED) |->
            (m_data.mode_code == aifa_pkg::MODE_IDLE) ||
            (m_data.mode_code == aifa_pkg::MODE_SUSPECT))
        else $error("alert fired from an impossible mode");

endmodule

bind audio_impact_fusion_alert_fsm aifa_checker u_aifa_checker (.*);
